@@ hw/rtl/pareto_pkg.sv @@
package pareto_pkg;

    // Archive geometry
    localparam int CAPACITY  = 64;
    localparam int OBJ_WIDTH = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream items
    localparam int SLOT_W    = 6;
    localparam int OUT_CNT_W = 7;
    localparam int WIDE_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // Input tdata layout: obj_a, obj_b, slot_index
    localparam int IN_A_LSB    = 0;
    localparam int IN_B_LSB    = OBJ_WIDTH;
    localparam int IN_SLOT_LSB = 2 * OBJ_WIDTH;
    localparam int IN_W        = 2 * OBJ_WIDTH + SLOT_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int OUT_W       = 3 + 2 * OUT_CNT_W + 1 + 2 * OBJ_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Item kinds carried on s_axis_tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef logic signed [OBJ_WIDTH-1:0] obj_t;

    // Relation of the candidate to one stored entry
    typedef struct packed {
        logic dominates;  // candidate dominates entry
        logic covered;    // entry dominates or equals candidate
    } rel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_RDOUT,
        ST_FINISH
    } state_t;

endpackage

@@ hw/rtl/pareto_cmp.sv @@
module pareto_cmp (
    input  pareto_pkg::obj_t cand_a,
    input  pareto_pkg::obj_t cand_b,
    input  pareto_pkg::obj_t ent_a,
    input  pareto_pkg::obj_t ent_b,
    output pareto_pkg::rel_t rel
);
    import pareto_pkg::*;

    logic a_lt, b_lt, a_le, b_le, ea_le, eb_le;

    // Signed two's-complement compares, shared by every slot of the scan
    always_comb begin
        a_lt  = cand_a < ent_a;
        b_lt  = cand_b < ent_b;
        a_le  = cand_a <= ent_a;
        b_le  = cand_b <= ent_b;
        ea_le = ent_a <= cand_a;
        eb_le = ent_b <= cand_b;
        rel.dominates = a_le && b_le && (a_lt || b_lt);
        rel.covered   = ea_le && eb_le;
    end

endmodule

@@ hw/rtl/pareto_mem.sv @@
module pareto_mem (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [pareto_pkg::IDX_W-1:0] waddr,
    input  pareto_pkg::obj_t             wdata_a,
    input  pareto_pkg::obj_t             wdata_b,
    input  logic                         re,
    input  logic [pareto_pkg::IDX_W-1:0] raddr,
    output pareto_pkg::obj_t             rdata_a,
    output pareto_pkg::obj_t             rdata_b
);
    import pareto_pkg::*;

    obj_t mem_a [CAPACITY];
    obj_t mem_b [CAPACITY];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_a[waddr] <= wdata_a;
            mem_b[waddr] <= wdata_b;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem_a[raddr];
            rdata_b <= mem_b[raddr];
        end
    end

endmodule

@@ hw/rtl/pareto_archive_two_objective.sv @@
// Two-objective Pareto archive, both objectives minimized, signed Q16.16.
// Input channel s_axis: tuser selects insert (0) or slot read (1); tdata
// carries obj_a, obj_b and slot_index. Each item yields one result on
// m_axis with the insert outcome, the archive size and the read slot data.
// Insert: the candidate is compared with one slot per cycle through a single
// shared compare unit reading the slot memory over its one read port; the
// scan covers every slot, then the sequencer passes through the drain,
// commit and finish states. A read passes through the readout and finish
// states. One item is processed at a time; s_axis_tready is high only
// while the sequencer is idle, which starts the cycle after the hand-off,
// so a new item is accepted only once the previous one is through.
// The result sits in an output register: a stalled receiver does not stop
// the next item from being accepted and scanned, only its final hand-off
// waits until the pending result is taken.
// Reset (aresetn low, synchronous) empties the archive at once: all valid
// bits and the size clear, no clearing pass is needed.
module pareto_archive_two_objective (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // obj_a, obj_b, slot_index (lowest bit up)
    input  logic [pareto_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // accepted, rejected_dominated, dropped_full, removed_count,
    // archive_size, read_valid, read_a, read_b (lowest bit up)
    output logic [pareto_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pareto_pkg::*;

    state_t state_reg, state_next;

    logic                 in_acc;
    logic                 out_free;
    obj_t                 in_a, in_b;
    logic [WIDE_W-1:0]    slot_wide;
    logic                 slot_in_range;

    obj_t                 cand_a_reg, cand_b_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 cmp_vld_reg;
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [CAPACITY-1:0]  kill_reg;
    logic                 rej_reg;
    logic [CNT_W-1:0]     removed_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 rd_ok_reg;

    logic                 res_acc_reg, res_rej_reg, res_drop_reg, res_rvalid_reg;
    logic [OUT_CNT_W-1:0] res_removed_reg, res_size_reg;
    obj_t                 res_a_reg, res_b_reg;

    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    obj_t                 rd_a, rd_b;
    rel_t                 rel;
    logic                 ent_valid;
    logic                 ent_kill;
    logic                 commit_write;

    // Unpack input item
    assign in_a          = s_axis_tdata[IN_A_LSB +: OBJ_WIDTH];
    assign in_b          = s_axis_tdata[IN_B_LSB +: OBJ_WIDTH];
    assign slot_wide     = WIDE_W'(s_axis_tdata[IN_SLOT_LSB +: SLOT_W]);
    assign slot_in_range = {1'b0, slot_wide} < (WIDE_W + 1)'(CAPACITY);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    pareto_mem u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (free_idx_reg),
        .wdata_a (cand_a_reg),
        .wdata_b (cand_b_reg),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    pareto_cmp u_cmp (
        .cand_a (cand_a_reg),
        .cand_b (cand_b_reg),
        .ent_a  (rd_a),
        .ent_b  (rd_b),
        .rel    (rel)
    );

    assign ent_valid    = valid_reg[cmp_idx_reg];
    assign ent_kill     = ent_valid && rel.dominates;
    assign commit_write = !rej_reg && free_found_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_axis_tuser == FUNC_READ) ? ST_RDOUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == IDX_W'(CAPACITY - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_FINISH;
            ST_RDOUT:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_raddr     = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_re        = s_axis_tvalid && (s_axis_tuser == FUNC_READ);
                mem_raddr     = slot_wide[IDX_W-1:0];
            end
            ST_SCAN:   mem_re = 1'b1;
            ST_COMMIT: mem_we = commit_write;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Archive update at commit, unless rejected: drop dominated slots, place candidate in a free slot
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (!rej_reg) begin
            valid_next = valid_reg & ~kill_reg;
            count_next = count_reg - removed_reg;
            if (free_found_reg) begin
                valid_next[free_idx_reg] = 1'b1;
                count_next = count_reg - removed_reg + CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_COMMIT) begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Scan datapath
    always_ff @(posedge aclk) begin
        cmp_vld_reg <= (state_reg == ST_SCAN);
        cmp_idx_reg <= idx_reg;
        if (state_reg == ST_SCAN) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (in_acc) begin
            cand_a_reg     <= in_a;
            cand_b_reg     <= in_b;
            idx_reg        <= '0;
            kill_reg       <= '0;
            rej_reg        <= 1'b0;
            removed_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            rd_ok_reg      <= slot_in_range && valid_reg[slot_wide[IDX_W-1:0]];
        end else if (cmp_vld_reg) begin
            kill_reg[cmp_idx_reg] <= ent_kill;
            if (ent_valid && rel.covered) begin
                rej_reg <= 1'b1;
            end
            if (ent_kill) begin
                removed_reg <= removed_reg + CNT_W'(1);
            end
            // Remember the lowest slot that is free after removal
            if (!free_found_reg && (!ent_valid || ent_kill)) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
        end
    end

    // Build the result
    always_ff @(posedge aclk) begin
        if (state_reg == ST_COMMIT) begin
            res_acc_reg     <= commit_write;
            res_rej_reg     <= rej_reg;
            res_drop_reg    <= !rej_reg && !free_found_reg;
            res_removed_reg <= rej_reg ? '0 : OUT_CNT_W'(removed_reg);
            res_size_reg    <= OUT_CNT_W'(count_next);
            res_rvalid_reg  <= 1'b0;
            res_a_reg       <= '0;
            res_b_reg       <= '0;
        end else if (state_reg == ST_RDOUT) begin
            res_acc_reg     <= 1'b0;
            res_rej_reg     <= 1'b0;
            res_drop_reg    <= 1'b0;
            res_removed_reg <= '0;
            res_size_reg    <= OUT_CNT_W'(count_reg);
            res_rvalid_reg  <= rd_ok_reg;
            res_a_reg       <= rd_ok_reg ? rd_a : '0;
            res_b_reg       <= rd_ok_reg ? rd_b : '0;
        end
    end

    // Hand the result to the output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= OUT_TDATA_W'({res_b_reg, res_a_reg, res_rvalid_reg,
                                         res_size_reg, res_removed_reg,
                                         res_drop_reg, res_rej_reg, res_acc_reg});
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Size matches the number of valid slots whenever the sequencer rests
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> count_reg == CNT_W'($countones(valid_reg)))
        else $error("archive size differs from valid slot count");

    // Size never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("archive size beyond capacity");

    // The candidate only lands in a slot that is free after removal
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !(valid_reg[free_idx_reg] && !kill_reg[free_idx_reg]))
        else $error("candidate written over a live slot");

    // At most one insert outcome per result
    a_outcome_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
        else $error("conflicting insert outcome flags");

endmodule
